[rtl/core/rof_pkg.sv]
// Shared constants, types and codes for the range outlier filter.
package rof_pkg;

   localparam int SAMPLE_BITS    = 16;
   localparam int RANGE_BITS     = 16;
   localparam int CSR_BITS       = 16;
   localparam int CSR_INDEX_BITS = 1;
   localparam int WIN_DEPTH      = 4;
   localparam int WIN_IDX_BITS   = $clog2(WIN_DEPTH);
   localparam int FILL_BITS      = $clog2(WIN_DEPTH + 1);

   // |4x - S| fits in two bits more than a sample
   localparam int DIFF_BITS   = SAMPLE_BITS + 2;
   localparam int SQ_BITS     = 2 * DIFF_BITS;
   localparam int SQ_SUM_BITS = SQ_BITS + WIN_IDX_BITS;
   localparam int SPREAD_SQ_BITS = 2 * CSR_BITS;
   localparam int LIM_BITS    = SPREAD_SQ_BITS + 6;
   localparam int CMP_BITS    = (SQ_SUM_BITS > LIM_BITS) ? SQ_SUM_BITS : LIM_BITS;
   localparam int NEAR_BITS   = (DIFF_BITS > CSR_BITS + 2) ? DIFF_BITS : CSR_BITS + 2;

   localparam int QUEUE_DEPTH    = 2;
   localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

   localparam logic [CSR_BITS-1:0] SPREAD_RESET = CSR_BITS'(300);
   localparam logic [CSR_BITS-1:0] NEAR_RESET   = CSR_BITS'(200);

   typedef logic [SAMPLE_BITS-1:0] sample_type;
   typedef logic [RANGE_BITS-1:0]  range_type;
   typedef sample_type [WIN_DEPTH-1:0] window_type;

   typedef enum logic [1:0] {
      VERDICT_PASS   = 2'd0,
      VERDICT_SPREAD = 2'd1,
      VERDICT_NEAR   = 2'd2,
      VERDICT_ORDER  = 2'd3
   } verdict_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_SPREAD = 1'b0,
      CSR_NEAR   = 1'b1
   } csr_index_type;

endpackage

[rtl/core/rof_req_if.sv]
// Sample input channel: valid, ready and one range sample.
interface rof_req_if;
   import rof_pkg::*;

   logic      valid;
   logic      ready;
   range_type range_sample;

   modport source (output valid, output range_sample, input ready);
   modport sink   (input valid, input range_sample, output ready);
endinterface

[rtl/core/rof_rsp_if.sv]
// Result channel: valid, ready, filtered range and verdict.
interface rof_rsp_if;
   import rof_pkg::*;

   logic        valid;
   logic        ready;
   range_type   filtered_range;
   verdict_type verdict;

   modport source (output valid, output filtered_range, output verdict, input ready);
   modport sink   (input valid, input filtered_range, input verdict, output ready);
endinterface

[rtl/core/range_outlier_filter.sv]
// Range outlier filter top level: configuration registers and front/queue/back wiring.
//
// Range samples (millimetres) enter on req_chan; the first four only fill the
// window and give no result. From then on each sample releases the oldest one
// on rsp_chan, either unchanged with verdict 0 or as zero with verdict 1
// (spread), 2 (far from mean) or 3 (not monotonic). One sample is taken every
// clock while the queue has room; from the edge that took its sample, a result
// goes through the snapshot queue, the difference stage, the square stage and
// the compare/output register. A two-entry queue lets intake run on while results
// stall. csr_index 0 writes spread_limit (reset 300), 1 writes near_limit
// (reset 200); write them only while the block is idle.
module range_outlier_filter (
   input  logic                               clock,
   input  logic                               reset,
   rof_req_if.sink                            req_chan,
   rof_rsp_if.source                          rsp_chan,
   input  logic                               csr_wr_en,
   input  logic [rof_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [rof_pkg::CSR_BITS-1:0]       csr_wr_data
);
   import rof_pkg::*;

   logic [CSR_BITS-1:0]       spread_limit_ff, spread_limit_in;
   logic [CSR_BITS-1:0]       near_limit_ff, near_limit_in;
   logic [SPREAD_SQ_BITS-1:0] spread_sq_ff, spread_sq_in;

   logic       push_valid, queue_full, pop_valid, pop_ready;
   window_type push_data, pop_data;

   always_comb begin
      spread_limit_in = spread_limit_ff;
      near_limit_in   = near_limit_ff;
      if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_SPREAD: spread_limit_in = csr_wr_data;
            CSR_NEAR:   near_limit_in   = csr_wr_data;
            default:    ;
         endcase
      end
      // square the limit once, off the item path
      spread_sq_in = SPREAD_SQ_BITS'(spread_limit_ff) * SPREAD_SQ_BITS'(spread_limit_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         spread_limit_ff <= SPREAD_RESET;
         near_limit_ff   <= NEAR_RESET;
         spread_sq_ff    <= SPREAD_SQ_BITS'(SPREAD_RESET) * SPREAD_SQ_BITS'(SPREAD_RESET);
      end else begin
         spread_limit_ff <= spread_limit_in;
         near_limit_ff   <= near_limit_in;
         spread_sq_ff    <= spread_sq_in;
      end
   end

   rof_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .queue_full (queue_full),
      .push_valid (push_valid),
      .push_data  (push_data)
   );

   rof_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .full       (queue_full),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   rof_back u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data),
      .near_limit (near_limit_ff),
      .spread_sq  (spread_sq_ff),
      .rsp_chan   (rsp_chan)
   );

endmodule

[rtl/core/rof_queue.sv]
// Two-entry queue of window snapshots between the front and the back.
module rof_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   input  rof_pkg::window_type push_data,
   output logic                full,
   output logic                pop_valid,
   input  logic                pop_ready,
   output rof_pkg::window_type pop_data
);
   import rof_pkg::*;

   window_type                mem_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_BITS-1:0] count_ff, count_in;
   logic                      push, pop;

   assign full      = (count_ff == QUEUE_CNT_BITS'(QUEUE_DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_data  = mem_ff[rd_ptr_ff];
   assign push      = push_valid && !full;
   assign pop       = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QUEUE_CNT_BITS'(QUEUE_DEPTH))
      else $error("queue count beyond depth");

   a_ptr_track: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0 || count_ff == QUEUE_CNT_BITS'(QUEUE_DEPTH)) |-> wr_ptr_ff == rd_ptr_ff)
      else $error("queue pointers disagree with count");

endmodule

[rtl/core/rof_front.sv]
// Front: takes samples, fills the window and hands full-window snapshots to the queue.
module rof_front (
   input  logic                clock,
   input  logic                reset,
   rof_req_if.sink             req_chan,
   input  logic                queue_full,
   output logic                push_valid,
   output rof_pkg::window_type push_data
);
   import rof_pkg::*;

   window_type            window_ff, window_in;
   logic [FILL_BITS-1:0]  fill_ff, fill_in;
   logic                  accept, win_full;
   sample_type            sample;

   assign req_chan.ready = !queue_full;
   assign accept         = req_chan.valid && req_chan.ready;
   assign win_full       = (fill_ff == FILL_BITS'(WIN_DEPTH));
   assign sample         = sample_type'(req_chan.range_sample);
   assign push_valid     = accept && win_full;
   assign push_data      = window_ff;

   always_comb begin
      window_in = window_ff;
      fill_in   = fill_ff;
      if (accept) begin
         if (win_full) begin
            // drop the oldest, append the newest
            for (int i = 0; i < WIN_DEPTH - 1; i++) begin
               window_in[i] = window_ff[i + 1];
            end
            window_in[WIN_DEPTH - 1] = sample;
         end else begin
            window_in[fill_ff[WIN_IDX_BITS-1:0]] = sample;
            fill_in = fill_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= '0;
         fill_ff   <= '0;
      end else begin
         window_ff <= window_in;
         fill_ff   <= fill_in;
      end
   end

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_BITS'(WIN_DEPTH))
      else $error("fill count beyond window depth");

   a_push_full: assert property (@(posedge clock) disable iff (reset)
      push_valid |-> !queue_full && win_full)
      else $error("snapshot pushed without full window or queue space");

endmodule

[rtl/core/rof_back.sv]
// Back: three-stage check pipeline (differences, squares, compare) with output register.
module rof_back (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 pop_valid,
   output logic                                 pop_ready,
   input  rof_pkg::window_type                  pop_data,
   input  logic [rof_pkg::CSR_BITS-1:0]         near_limit,
   input  logic [rof_pkg::SPREAD_SQ_BITS-1:0]   spread_sq,
   rof_rsp_if.source                            rsp_chan
);
   import rof_pkg::*;

   // stage 1: |4x - S| per lane, near and order flags
   logic                 s1_valid_ff, s1_valid_in;
   logic [DIFF_BITS-1:0] s1_diff_ff [WIN_DEPTH];
   logic [DIFF_BITS-1:0] s1_diff_in [WIN_DEPTH];
   logic                 s1_near_ff, s1_near_in;
   logic                 s1_order_ff, s1_order_in;
   sample_type           s1_oldest_ff;

   // stage 2: squares
   logic                 s2_valid_ff, s2_valid_in;
   logic [SQ_BITS-1:0]   s2_sq_ff [WIN_DEPTH];
   logic [SQ_BITS-1:0]   s2_sq_in [WIN_DEPTH];
   logic                 s2_near_ff, s2_order_ff;
   sample_type           s2_oldest_ff;

   // output register
   logic                 out_valid_ff, out_valid_in;
   range_type            out_range_ff, out_range_in;
   verdict_type          out_verdict_ff, out_verdict_in;

   logic                   out_take, s2_take, s1_take;
   logic [DIFF_BITS-1:0]   win_sum;
   logic [DIFF_BITS-1:0]   times4;
   logic [SQ_SUM_BITS-1:0] sq_sum;
   logic                   spread_fail;
   sample_type             a, b, c;

   assign out_take  = !out_valid_ff || rsp_chan.ready;
   assign s2_take   = !s2_valid_ff || out_take;
   assign s1_take   = !s1_valid_ff || s2_take;
   assign pop_ready = s1_take;

   assign rsp_chan.valid          = out_valid_ff;
   assign rsp_chan.filtered_range = out_range_ff;
   assign rsp_chan.verdict        = out_verdict_ff;

   always_comb begin
      win_sum = '0;
      for (int i = 0; i < WIN_DEPTH; i++) begin
         win_sum = win_sum + DIFF_BITS'(pop_data[i]);
      end
      for (int i = 0; i < WIN_DEPTH; i++) begin
         times4        = {pop_data[i], 2'b00};
         s1_diff_in[i] = (times4 >= win_sum) ? times4 - win_sum : win_sum - times4;
      end
      s1_near_in  = NEAR_BITS'(s1_diff_in[0]) > NEAR_BITS'({near_limit, 2'b00});
      a = pop_data[0];
      b = pop_data[1];
      c = pop_data[2];
      s1_order_in = !((a <= b && b <= c) || (a >= b && b >= c));
      s1_valid_in = s1_take ? pop_valid : s1_valid_ff;
   end

   always_comb begin
      for (int i = 0; i < WIN_DEPTH; i++) begin
         s2_sq_in[i] = SQ_BITS'(s1_diff_ff[i]) * SQ_BITS'(s1_diff_ff[i]);
      end
      s2_valid_in = s2_take ? s1_valid_ff : s2_valid_ff;
   end

   always_comb begin
      sq_sum = '0;
      for (int i = 0; i < WIN_DEPTH; i++) begin
         sq_sum = sq_sum + SQ_SUM_BITS'(s2_sq_ff[i]);
      end
      spread_fail = CMP_BITS'(sq_sum) > CMP_BITS'({spread_sq, 6'b000000});
      priority if (spread_fail) begin
         out_verdict_in = VERDICT_SPREAD;
      end else if (s2_near_ff) begin
         out_verdict_in = VERDICT_NEAR;
      end else if (s2_order_ff) begin
         out_verdict_in = VERDICT_ORDER;
      end else begin
         out_verdict_in = VERDICT_PASS;
      end
      out_range_in = (out_verdict_in == VERDICT_PASS) ? range_type'(s2_oldest_ff) : '0;
      out_valid_in = out_take ? s2_valid_ff : out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_take) begin
         s1_diff_ff   <= s1_diff_in;
         s1_near_ff   <= s1_near_in;
         s1_order_ff  <= s1_order_in;
         s1_oldest_ff <= pop_data[0];
      end
      if (s2_take) begin
         s2_sq_ff     <= s2_sq_in;
         s2_near_ff   <= s1_near_ff;
         s2_order_ff  <= s1_order_ff;
         s2_oldest_ff <= s1_oldest_ff;
      end
      if (out_take) begin
         out_range_ff   <= out_range_in;
         out_verdict_ff <= out_verdict_in;
      end
   end

   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_verdict_ff != VERDICT_PASS) |-> out_range_ff == '0)
      else $error("rejected sample not zeroed");

   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s2_take) |=> s1_valid_ff && $stable(s1_oldest_ff))
      else $error("stage 1 lost an item under stall");

endmodule

[verif/rof_result_checker.sv]
// Predicts range_outlier_filter results from observed transfers and compares them.
`timescale 1ns / 100ps
module rof_result_checker (
   input  logic                               clock,
   input  logic                               reset,
   rof_req_if                                 req_mon,
   rof_rsp_if                                 rsp_mon,
   input  logic                               csr_wr_en,
   input  logic [rof_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [rof_pkg::CSR_BITS-1:0]       csr_wr_data,
   output int                                 mismatch_count,
   output int                                 results_pending
);
   import rof_pkg::*;

   typedef struct packed {
      range_type   filtered_range;
      verdict_type verdict;
   } range_result_type;

   logic [CSR_BITS-1:0] spread_lim;
   logic [CSR_BITS-1:0] near_lim;
   window_type          history;
   int unsigned         held;
   range_result_type    due_results[$];

   function automatic logic [63:0] offset_from_sum(input sample_type x, input logic [63:0] total);
      logic [63:0] scaled;
      scaled = 64'(x) << 2;
      return (scaled >= total) ? scaled - total : total - scaled;
   endfunction

   function automatic verdict_type grade_window(input window_type w,
                                                input logic [CSR_BITS-1:0] spread,
                                                input logic [CSR_BITS-1:0] near);
      logic [63:0] total;
      logic [63:0] quad;
      logic [63:0] dev;
      int          idx;
      total = '0;
      quad  = '0;
      for (idx = 0; idx < WIN_DEPTH; idx++)
         total += 64'(w[idx]);
      for (idx = 0; idx < WIN_DEPTH; idx++) begin
         dev = offset_from_sum(w[idx], total);
         quad += dev * dev;
      end
      // spread first, then distance of the oldest from the mean, then order
      if (quad > 64'd64 * 64'(spread) * 64'(spread))
         return VERDICT_SPREAD;
      if (offset_from_sum(w[0], total) > 64'(near) << 2)
         return VERDICT_NEAR;
      if (!((w[0] <= w[1] && w[1] <= w[2]) || (w[0] >= w[1] && w[1] >= w[2])))
         return VERDICT_ORDER;
      return VERDICT_PASS;
   endfunction

   always @(posedge clock) begin
      range_result_type want;
      verdict_type      grade;
      int               idx;
      if (reset) begin
         spread_lim = SPREAD_RESET;
         near_lim   = NEAR_RESET;
         history    = '0;
         held       = 0;
         due_results.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (due_results.size() == 0) begin
               $display("%0t: unexpected result: expected none, actual range %0d verdict %0d",
                        $time, rsp_mon.filtered_range, rsp_mon.verdict);
               mismatch_count++;
            end else begin
               want = due_results.pop_front();
               if (rsp_mon.filtered_range !== want.filtered_range) begin
                  $display("%0t: filtered_range mismatch: expected %0d, actual %0d",
                           $time, want.filtered_range, rsp_mon.filtered_range);
                  mismatch_count++;
               end
               if (rsp_mon.verdict !== want.verdict) begin
                  $display("%0t: verdict mismatch: expected %0d, actual %0d",
                           $time, want.verdict, rsp_mon.verdict);
                  mismatch_count++;
               end
            end
         end
         if (csr_wr_en) begin
            case (csr_index)
               CSR_SPREAD: spread_lim = csr_wr_data;
               CSR_NEAR:   near_lim   = csr_wr_data;
               default:    ;
            endcase
         end
         if (req_mon.valid && req_mon.ready) begin
            if (held < WIN_DEPTH) begin
               history[held] = req_mon.range_sample;
               held++;
            end else begin
               grade = grade_window(history, spread_lim, near_lim);
               want.verdict        = grade;
               want.filtered_range = (grade == VERDICT_PASS) ? history[0] : '0;
               due_results.push_back(want);
               // drop the oldest, the new sample enters as the newest
               for (idx = 0; idx < WIN_DEPTH - 1; idx++)
                  history[idx] = history[idx + 1];
               history[WIN_DEPTH - 1] = req_mon.range_sample;
            end
         end
      end
      results_pending = due_results.size();
   end

endmodule

[verif/tb.sv]
// Stimulus and verdict for the range_outlier_filter regression.
`timescale 1ns / 100ps
module tb;
   import rof_pkg::*;

   logic                      clock;
   logic                      reset;
   logic                      csr_wr_en;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CSR_BITS-1:0]       csr_wr_data;
   int                        mismatch_count;
   int                        results_pending;

   bit calm;
   bit hold_request;
   int track;
   int drift;
   int jitter_mm;

   sample_type directed_ranges [24] = '{
      16'd1000, 16'd1000, 16'd1000, 16'd1000, 16'd1000, 16'd1100, 16'd1000, 16'd1050,
      16'd1000, 16'd1300, 16'd1300, 16'd1300, 16'd1300, 16'd1200, 16'd1100, 16'd65535,
      16'd0,    16'd65535, 16'd65535, 16'd65535, 16'd65535, 16'd65535, 16'd0, 16'd0
   };

   rof_req_if req_if ();
   rof_rsp_if rsp_if ();

   range_outlier_filter uut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_if),
      .rsp_chan    (rsp_if),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   rof_result_checker result_check (
      .clock           (clock),
      .reset           (reset),
      .req_mon         (req_if),
      .rsp_mon         (rsp_if),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wr_data     (csr_wr_data),
      .mismatch_count  (mismatch_count),
      .results_pending (results_pending)
   );

   initial clock = 1'b0;
   always #1 clock = ~clock;

   task offer_range(input sample_type value);
      if (!calm && $urandom_range(99) < 13) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_if.valid        <= 1'b1;
      req_if.range_sample <= value;
      do @(posedge clock); while (!req_if.ready);
   endtask

   // hold intake until every result is out and the pipeline is quiet
   task settle;
      req_if.valid <= 1'b0;
      @(posedge clock);
      wait (results_pending == 0);
      repeat (6) @(posedge clock);
   endtask

   task write_limits(input logic [CSR_BITS-1:0] spread, input logic [CSR_BITS-1:0] near);
      csr_wr_en   <= 1'b1;
      csr_index   <= CSR_SPREAD;
      csr_wr_data <= spread;
      @(posedge clock);
      csr_index   <= CSR_NEAR;
      csr_wr_data <= near;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // mostly a drifting track with jitter, now and then a wild or extreme reading
   function automatic sample_type next_range();
      int pick;
      int level;
      pick = $urandom_range(99);
      if (pick < 6)
         return sample_type'($urandom_range(65535));
      if (pick < 9)
         return pick[0] ? 16'hFFFF : 16'h0000;
      if (pick < 14)
         drift = int'($urandom_range(100)) - 50;
      level = track + drift + int'($urandom_range(2 * jitter_mm)) - jitter_mm;
      if (level < 0)
         level = 0;
      if (level > 65535)
         level = 65535;
      track = level;
      return sample_type'(level);
   endfunction

   initial begin
      rsp_if.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_if.ready <= 1'b0;
            repeat (300) @(posedge clock);
         end
         rsp_if.ready <= calm || ($urandom_range(99) >= 13);
      end
   end

   initial begin
      #1_000_000;
      $display("range_outlier_filter regression: fail");
      $finish;
   end

   initial begin
      int phase;
      reset               = 1'b1;
      req_if.valid        = 1'b0;
      req_if.range_sample = '0;
      csr_wr_en           = 1'b0;
      csr_index           = CSR_SPREAD;
      csr_wr_data         = '0;
      calm                = 1'b0;
      hold_request        = 1'b0;
      track               = 1000;
      drift               = 0;
      jitter_mm           = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset limits still in force here
      foreach (directed_ranges[idx])
         offer_range(directed_ranges[idx]);
      settle();

      for (phase = 0; phase < 8; phase++) begin
         case (phase)
            0:       write_limits('0, '0);
            1:       write_limits(16'hFFFF, 16'hFFFF);
            2:       write_limits(16'd300, 16'd200);
            6:       write_limits(CSR_BITS'($urandom_range(65535)),
                                  CSR_BITS'($urandom_range(65535)));
            default: write_limits(CSR_BITS'($urandom_range(1500)),
                                  CSR_BITS'($urandom_range(1500)));
         endcase
         calm      = (phase == 3);
         jitter_mm = $urandom_range(400);
         drift     = int'($urandom_range(100)) - 50;
         track     = $urandom_range(200, 60000);
         // back up the result side so the block fills and stalls intake
         if (phase == 5)
            hold_request = 1'b1;
         repeat (210)
            offer_range(next_range());
         settle();
      end
      calm = 1'b0;

      if (mismatch_count == 0 && results_pending == 0)
         $display("range_outlier_filter regression: pass");
      else
         $display("range_outlier_filter regression: fail");
      $finish;
   end

endmodule

[files.f]
rtl/core/rof_pkg.sv
rtl/core/rof_req_if.sv
rtl/core/rof_rsp_if.sv
rtl/core/rof_queue.sv
rtl/core/rof_front.sv
rtl/core/rof_back.sv
rtl/core/range_outlier_filter.sv
verif/rof_result_checker.sv
verif/tb.sv
